// ===== design/isrt_pkg.sv =====
package isrt_pkg;

    localparam int VALUE_W       = 32;
    localparam int MAX_ITEMS_DEF = 64;
    localparam int QUEUE_DEPTH   = 2;

    typedef struct packed {
        logic signed [VALUE_W-1:0] value;
        logic                      last_item;
    } item_t;

    typedef enum logic [0:0] {
        ST_INSERT,
        ST_DRAIN
    } back_state_t;

endpackage

// ===== design/isrt_front.sv =====
module isrt_front (
    input  logic          aclk,
    input  logic          aresetn,
    input  logic          s_valid,
    output logic          s_ready,
    input  isrt_pkg::item_t s_item,
    output logic          q_valid,
    input  logic          q_ready,
    output isrt_pkg::item_t q_item
);
    import isrt_pkg::*;

    localparam int PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

    item_t            slot_reg [QUEUE_DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0] fill_reg, fill_next;
    logic             push, pop;

    assign s_ready = (fill_reg != CNT_W'(QUEUE_DEPTH));
    assign q_valid = (fill_reg != '0);
    assign q_item  = slot_reg[rd_ptr_reg];
    assign push    = s_valid && s_ready;
    assign pop     = q_valid && q_ready;

    always_comb begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        fill_next   = fill_reg;
        if (push) begin
            wr_ptr_next = (wr_ptr_reg == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (pop) begin
            rd_ptr_next = (rd_ptr_reg == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (push && !pop) begin
            fill_next = fill_reg + 1'b1;
        end else if (pop && !push) begin
            fill_next = fill_reg - 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            fill_reg   <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            fill_reg   <= fill_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (push) begin
            slot_reg[wr_ptr_reg] <= s_item;
        end
    end

endmodule

// ===== design/isrt_back.sv =====
module isrt_back #(
    parameter int MAX_ITEMS = isrt_pkg::MAX_ITEMS_DEF
) (
    input  logic                              aclk,
    input  logic                              aresetn,
    input  logic                              q_valid,
    output logic                              q_ready,
    input  isrt_pkg::item_t                   q_item,
    output logic                              m_valid,
    input  logic                              m_ready,
    output logic signed [isrt_pkg::VALUE_W-1:0] m_sorted_value,
    output logic                              m_last_result,
    output logic                              m_overflow
);
    import isrt_pkg::*;

    localparam int CNT_W = $clog2(MAX_ITEMS + 1);

    back_state_t               state_reg, state_next;
    logic [CNT_W-1:0]          count_reg, count_next;
    logic                      dropped_reg, dropped_next;
    logic signed [VALUE_W-1:0] cell_reg  [MAX_ITEMS];
    logic signed [VALUE_W-1:0] cell_next [MAX_ITEMS];
    logic [MAX_ITEMS-1:0]      take;
    logic                      full;
    logic                      do_insert, do_beat;

    assign full = (count_reg == CNT_W'(MAX_ITEMS));

    // take[i]: cell i receives the key or its lower neighbor
    always_comb begin
        for (int i = 0; i < MAX_ITEMS; i++) begin
            if (CNT_W'(i) < count_reg) begin
                take[i] = (cell_reg[i] > q_item.value);
            end else begin
                take[i] = (CNT_W'(i) == count_reg);
            end
        end
    end

    always_comb begin
        state_next     = state_reg;
        count_next     = count_reg;
        dropped_next   = dropped_reg;
        q_ready        = 1'b0;
        m_valid        = 1'b0;
        m_sorted_value = cell_reg[0];
        m_last_result  = (count_reg == CNT_W'(1));
        m_overflow     = dropped_reg;
        do_insert      = 1'b0;
        do_beat        = 1'b0;
        unique case (state_reg)
            ST_INSERT: begin
                q_ready = 1'b1;
                if (q_valid) begin
                    if (full) begin
                        dropped_next = 1'b1;
                    end else begin
                        do_insert  = 1'b1;
                        count_next = count_reg + 1'b1;
                    end
                    if (q_item.last_item) begin
                        state_next = ST_DRAIN;
                    end
                end
            end
            ST_DRAIN: begin
                m_valid = 1'b1;
                if (m_ready) begin
                    do_beat    = 1'b1;
                    count_next = count_reg - 1'b1;
                    if (count_reg == CNT_W'(1)) begin
                        state_next   = ST_INSERT;
                        dropped_next = 1'b0;
                    end
                end
            end
            default: begin
                state_next = ST_INSERT;
            end
        endcase
    end

    always_comb begin
        for (int i = 0; i < MAX_ITEMS; i++) begin
            cell_next[i] = cell_reg[i];
            if (do_insert && take[i]) begin
                if (i > 0 && take[(i > 0) ? i - 1 : 0]) begin
                    cell_next[i] = cell_reg[(i > 0) ? i - 1 : 0];
                end else begin
                    cell_next[i] = q_item.value;
                end
            end else if (do_beat && i < MAX_ITEMS - 1) begin
                // drain shifts the chain toward cell 0
                cell_next[i] = cell_reg[(i < MAX_ITEMS - 1) ? i + 1 : i];
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_INSERT;
            count_reg   <= '0;
            dropped_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            count_reg   <= count_next;
            dropped_reg <= dropped_next;
        end
    end

    always_ff @(posedge aclk) begin
        for (int i = 0; i < MAX_ITEMS; i++) begin
            cell_reg[i] <= cell_next[i];
        end
    end

endmodule

// ===== design/insertion_sorter.sv =====
// a closing item is registered in the queue, then inserted, and the state turns to drain
// throughput: one item per cycle enters the compare-and-shift cell chain while a set is
// collected and not full; a set of n held values then drains at one result per cycle
// while m_ready is high; a two-entry input queue keeps taking items during the drain
// reset: synchronous active low, clears queue, held count, drop flag and state;
// cell contents are left as they are
module insertion_sorter #(
    parameter int MAX_ITEMS = isrt_pkg::MAX_ITEMS_DEF
) (
    input  logic                              aclk,
    input  logic                              aresetn,
    input  logic                              s_valid,
    output logic                              s_ready,
    input  logic signed [isrt_pkg::VALUE_W-1:0] s_value,
    input  logic                              s_last_item,
    output logic                              m_valid,
    input  logic                              m_ready,
    output logic signed [isrt_pkg::VALUE_W-1:0] m_sorted_value,
    output logic                              m_last_result,
    output logic                              m_overflow
);
    import isrt_pkg::*;

    item_t s_item;
    item_t q_item;
    logic  q_valid, q_ready;

    assign s_item.value     = s_value;
    assign s_item.last_item = s_last_item;

    isrt_front u_front (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .s_item  (s_item),
        .q_valid (q_valid),
        .q_ready (q_ready),
        .q_item  (q_item)
    );

    isrt_back #(
        .MAX_ITEMS (MAX_ITEMS)
    ) u_back (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .q_valid        (q_valid),
        .q_ready        (q_ready),
        .q_item         (q_item),
        .m_valid        (m_valid),
        .m_ready        (m_ready),
        .m_sorted_value (m_sorted_value),
        .m_last_result  (m_last_result),
        .m_overflow     (m_overflow)
    );

endmodule

// ===== design/isrt_checker.sv =====
module isrt_checker (
    input logic                              aclk,
    input logic                              aresetn,
    input logic                              s_valid,
    input logic                              s_ready,
    input logic signed [isrt_pkg::VALUE_W-1:0] s_value,
    input logic                              s_last_item,
    input logic                              m_valid,
    input logic                              m_ready,
    input logic signed [isrt_pkg::VALUE_W-1:0] m_sorted_value,
    input logic                              m_last_result,
    input logic                              m_overflow
);

    // a stalled result beat holds
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_sorted_value)
            && $stable(m_last_result) && $stable(m_overflow))
        else $error("result beat changed while stalled");

    // a set drains without gaps and in ascending order
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_ready && !m_last_result |=>
            m_valid && (m_sorted_value >= $past(m_sorted_value)))
        else $error("results not ascending within a set");

    // overflow is the same on every beat of a set
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_ready && !m_last_result |=> m_overflow == $past(m_overflow))
        else $error("overflow changed within a set");

endmodule

bind insertion_sorter isrt_checker u_isrt_checker (.*);
